// File: src/cau_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the complex arithmetic unit: operation codes,
// datapath widths and the latency of the divide and root pipelines.
package cau_pkg;

    // operation codes
    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_SUB   = 4'd1;
    localparam logic [3:0] FUNC_MUL   = 4'd2;
    localparam logic [3:0] FUNC_DIV   = 4'd3;
    localparam logic [3:0] FUNC_CONJ  = 4'd4;
    localparam logic [3:0] FUNC_SCALE = 4'd5;
    localparam logic [3:0] FUNC_DIVR  = 4'd6;
    localparam logic [3:0] FUNC_SQMOD = 4'd7;
    localparam logic [3:0] FUNC_MOD   = 4'd8;
    localparam logic [3:0] FUNC_DIST  = 4'd9;
    localparam logic [3:0] FUNC_CMP   = 4'd10;
    localparam logic [3:0] FUNC_THR   = 4'd11;

    // register index
    localparam logic REG_THRESHOLD = 1'b0;

    localparam int DW = 32;           // operand and result width
    localparam int OW = DW + 1;       // multiplier operand width
    localparam int PW = 2 * OW;       // product width
    localparam int CW = PW + 1;       // sum of two products
    localparam int MW = 64;           // magnitude width fed to the divider

    localparam int DIV_STEPS  = 32;   // one quotient bit per stage
    localparam int SQRT_STEPS = 33;   // one root bit per stage
    // registers from the pipeline input to its output, both units alike
    localparam int PIPE_LAT   = SQRT_STEPS + 1;

endpackage

// File: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top level of the Q-format complex arithmetic unit with its APB register.
// Uses cau_pkg, cau_div_pipe and cau_sqrt_pipe.

// Takes one item per clock on start (busy stays low) and returns its result
// with o_done high for one cycle; results come out in order. Each item runs
// through three stages of operand select, 33x33 multiply and product sum,
// then alongside the divide and square-root pipelines (one bit per stage,
// 34 registers) and an output register. Every func takes the same path, so the result
// order matches the item order. The only register, threshold, sits at
// byte address 0 and should be written only while no item is in flight.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_done,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic signed [1:0]  o_cmp_sign,
    output logic               o_div_zero,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DW  = cau_pkg::DW;
    localparam int OW  = cau_pkg::OW;
    localparam int PW  = cau_pkg::PW;
    localparam int CW  = cau_pkg::CW;
    localparam int MW  = cau_pkg::MW;
    localparam int LAT = cau_pkg::PIPE_LAT;
    localparam int SST = cau_pkg::SQRT_STEPS;

    localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [3:0]    func;
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic [1:0]    cmp;
        logic          dz;
        logic          sat;
        logic          neg_re;
        logic          neg_im;
        logic          sq_sat;
    } t_side;

    // clamp a wide signed value to DW bits: {saturated, value}
    function automatic logic [DW:0] sat_clamp(input logic signed [CW-1:0] v);
        logic in_range;
        in_range = (&v[CW-1:DW-1]) | ~(|v[CW-1:DW-1]);
        if (in_range) begin
            return {1'b0, v[DW-1:0]};
        end
        return {1'b1, v[CW-1] ? NEG_MIN : POS_MAX};
    endfunction

    // clamp a quotient magnitude with its sign: {saturated, value}
    function automatic logic [DW:0] quo_clamp(input logic neg, input logic ovf,
                                              input logic [DW-1:0] q);
        if (!neg) begin
            if (ovf || q[DW-1]) begin
                return {1'b1, POS_MAX};
            end
            return {1'b0, q};
        end
        if (ovf || (q > NEG_MIN)) begin
            return {1'b1, NEG_MIN};
        end
        return {1'b0, DW'(~q + 1'b1)};
    endfunction

    // ---------------- configuration ----------------
    logic [30:0] r_threshold;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (w_wr && (paddr[2] == cau_pkg::REG_THRESHOLD)) begin
            r_threshold <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == cau_pkg::REG_THRESHOLD) ? {1'b0, r_threshold} : '0;

    assign busy = 1'b0;

    // ---------------- stage A: operand select, simple ops ----------------
    logic signed [OW-1:0] w_ar, w_ai, w_br, w_bi, w_dr, w_di, w_s, w_one;
    logic signed [OW-1:0] n_x [6];
    logic signed [OW-1:0] n_y [6];
    logic [DW:0]          n_sre;
    logic [DW:0]          n_sim;
    logic [DW-1:0]        w_mar, w_mai;
    logic [DW:0]          w_nar, w_nai, w_t;

    assign w_ar  = {i_a_re[DW-1], i_a_re};
    assign w_ai  = {i_a_im[DW-1], i_a_im};
    assign w_br  = {i_b_re[DW-1], i_b_re};
    assign w_bi  = {i_b_im[DW-1], i_b_im};
    assign w_dr  = w_ar - w_br;
    assign w_di  = w_ai - w_bi;
    assign w_one = OW'(1);
    assign w_s   = w_ar + w_br;
    assign w_nar = -w_ar;
    assign w_nai = -w_ai;
    assign w_mar = i_a_re[DW-1] ? w_nar[DW-1:0] : i_a_re;
    assign w_mai = i_a_im[DW-1] ? w_nai[DW-1:0] : i_a_im;
    assign w_t   = {2'b00, r_threshold};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_x[k] = '0;
            n_y[k] = '0;
        end
        n_sre = '0;
        n_sim = '0;
        unique case (i_func) inside
            cau_pkg::FUNC_ADD: begin
                n_sre = sat_clamp(CW'(w_s));
                n_sim = sat_clamp(CW'(w_ai + w_bi));
            end
            cau_pkg::FUNC_SUB: begin
                n_sre = sat_clamp(CW'(w_dr));
                n_sim = sat_clamp(CW'(w_di));
            end
            cau_pkg::FUNC_CONJ: begin
                n_sre = {1'b0, i_a_re};
                n_sim = sat_clamp(CW'($signed(w_nai)));
            end
            cau_pkg::FUNC_THR: begin
                n_sre = {1'b0, ({1'b0, w_mar} < w_t) ? {DW{1'b0}} : i_a_re};
                n_sim = {1'b0, ({1'b0, w_mai} < w_t) ? {DW{1'b0}} : i_a_im};
            end
            cau_pkg::FUNC_MUL: begin
                n_x[0] = w_ar; n_y[0] = w_br;
                n_x[1] = w_ai; n_y[1] = -w_bi;
                n_x[2] = w_ar; n_y[2] = w_bi;
                n_x[3] = w_ai; n_y[3] = w_br;
            end
            cau_pkg::FUNC_DIV: begin
                n_x[0] = w_ar; n_y[0] = w_br;
                n_x[1] = w_ai; n_y[1] = w_bi;
                n_x[2] = w_ar; n_y[2] = -w_bi;
                n_x[3] = w_ai; n_y[3] = w_br;
                n_x[4] = w_br; n_y[4] = w_br;
                n_x[5] = w_bi; n_y[5] = w_bi;
            end
            cau_pkg::FUNC_SCALE: begin
                n_x[0] = w_ar; n_y[0] = w_br;
                n_x[3] = w_ai; n_y[3] = w_br;
            end
            cau_pkg::FUNC_DIVR: begin
                // pass a and the scalar through the products unchanged
                n_x[0] = w_ar; n_y[0] = w_one;
                n_x[3] = w_ai; n_y[3] = w_one;
                n_x[4] = w_br; n_y[4] = w_one;
            end
            cau_pkg::FUNC_SQMOD, cau_pkg::FUNC_MOD: begin
                n_x[0] = w_ar; n_y[0] = w_ar;
                n_x[1] = w_ai; n_y[1] = w_ai;
            end
            cau_pkg::FUNC_DIST: begin
                n_x[0] = w_dr; n_y[0] = w_dr;
                n_x[1] = w_di; n_y[1] = w_di;
            end
            cau_pkg::FUNC_CMP: begin
                n_x[0] = w_ar; n_y[0] = w_ar;
                n_x[1] = w_ai; n_y[1] = w_ai;
                n_x[4] = w_br; n_y[4] = w_br;
                n_x[5] = w_bi; n_y[5] = w_bi;
            end
            default: begin
            end
        endcase
    end

    logic                 r_a_valid;
    logic [3:0]           r_a_func;
    logic signed [OW-1:0] r_x [6];
    logic signed [OW-1:0] r_y [6];
    logic [DW:0]          r_a_sre, r_a_sim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_func <= i_func;
        r_a_sre  <= n_sre;
        r_a_sim  <= n_sim;
        for (int k = 0; k < 6; k++) begin
            r_x[k] <= n_x[k];
            r_y[k] <= n_y[k];
        end
    end

    // ---------------- stage B: products ----------------
    logic                 r_b_valid;
    logic [3:0]           r_b_func;
    logic signed [PW-1:0] r_p [6];
    logic [DW:0]          r_b_sre, r_b_sim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_func <= r_a_func;
        r_b_sre  <= r_a_sre;
        r_b_sim  <= r_a_sim;
        for (int k = 0; k < 6; k++) begin
            r_p[k] <= r_x[k] * r_y[k];
        end
    end

    // ---------------- stage C: product sums ----------------
    logic                 r_c_valid;
    logic [3:0]           r_c_func;
    logic signed [CW-1:0] r_c0, r_c1, r_c2;
    logic [DW:0]          r_c_sre, r_c_sim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_func <= r_b_func;
        r_c_sre  <= r_b_sre;
        r_c_sim  <= r_b_sim;
        r_c0     <= CW'(r_p[0]) + CW'(r_p[1]);
        r_c1     <= CW'(r_p[2]) + CW'(r_p[3]);
        r_c2     <= CW'(r_p[4]) + CW'(r_p[5]);
    end

    // ---------------- stage D: shift, compare, unit setup ----------------
    logic signed [CW-1:0] w_sh0, w_sh1, w_n0, w_n1, w_n2;
    logic [DW:0]          w_f0, w_f1;
    logic [MW-1:0]        w_m0, w_m1, w_m2;
    logic [2*SST-1:0]     w_rad;
    t_side                n_side;

    assign w_sh0 = r_c0 >>> FRAC_BITS;
    assign w_sh1 = r_c1 >>> FRAC_BITS;
    assign w_f0  = sat_clamp(w_sh0);
    assign w_f1  = sat_clamp(w_sh1);
    assign w_n0  = -r_c0;
    assign w_n1  = -r_c1;
    assign w_n2  = -r_c2;
    assign w_m0  = r_c0[CW-1] ? w_n0[MW-1:0] : r_c0[MW-1:0];
    assign w_m1  = r_c1[CW-1] ? w_n1[MW-1:0] : r_c1[MW-1:0];
    assign w_m2  = r_c2[CW-1] ? w_n2[MW-1:0] : r_c2[MW-1:0];
    assign w_rad = (2*SST)'(r_c0[61:0]);

    always_comb begin
        n_side        = '0;
        n_side.func   = r_c_func;
        n_side.neg_re = r_c0[CW-1] ^ r_c2[CW-1];
        n_side.neg_im = r_c1[CW-1] ^ r_c2[CW-1];
        n_side.dz     = (r_c2 == '0);
        n_side.sq_sat = |r_c0[CW-1:62];
        unique case (r_c_func) inside
            cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB, cau_pkg::FUNC_CONJ,
            cau_pkg::FUNC_THR: begin
                n_side.re  = r_c_sre[DW-1:0];
                n_side.im  = r_c_sim[DW-1:0];
                n_side.sat = r_c_sre[DW] | r_c_sim[DW];
            end
            cau_pkg::FUNC_MUL, cau_pkg::FUNC_SCALE: begin
                n_side.re  = w_f0[DW-1:0];
                n_side.im  = w_f1[DW-1:0];
                n_side.sat = w_f0[DW] | w_f1[DW];
            end
            cau_pkg::FUNC_SQMOD: begin
                n_side.re  = w_f0[DW-1:0];
                n_side.sat = w_f0[DW];
            end
            cau_pkg::FUNC_CMP: begin
                if (r_c0 > r_c2) begin
                    n_side.cmp = 2'b01;
                end else if (r_c0 < r_c2) begin
                    n_side.cmp = 2'b11;
                end
            end
            default: begin
            end
        endcase
    end

    logic [DW-1:0]  w_q_re, w_q_im;
    logic           w_ovf_re, w_ovf_im;
    logic [SST-1:0] w_root;

    cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .i_clk (i_clk),
        .i_num (w_m0),
        .i_den (w_m2),
        .o_quo (w_q_re),
        .o_ovf (w_ovf_re)
    );

    cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .i_clk (i_clk),
        .i_num (w_m1),
        .i_den (w_m2),
        .o_quo (w_q_im),
        .o_ovf (w_ovf_im)
    );

    cau_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (w_rad),
        .o_root (w_root)
    );

    // side data rides alongside the unit pipelines
    logic [LAT-1:0] r_sv;
    t_side          r_side [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else begin
            r_sv <= {r_sv[LAT-2:0], r_c_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int k = 1; k < LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stage E: finish and output ----------------
    t_side       w_e;
    logic [DW:0] w_dre, w_dim;
    logic [DW-1:0] n_re, n_im;
    logic [1:0]  n_cmp;
    logic        n_dz, n_sat;

    assign w_e   = r_side[LAT-1];
    assign w_dre = quo_clamp(w_e.neg_re, w_ovf_re, w_q_re);
    assign w_dim = quo_clamp(w_e.neg_im, w_ovf_im, w_q_im);

    always_comb begin
        n_re  = w_e.re;
        n_im  = w_e.im;
        n_cmp = w_e.cmp;
        n_dz  = 1'b0;
        n_sat = w_e.sat;
        unique case (w_e.func) inside
            cau_pkg::FUNC_DIV, cau_pkg::FUNC_DIVR: begin
                if (w_e.dz) begin
                    n_re  = '0;
                    n_im  = '0;
                    n_dz  = 1'b1;
                    n_sat = 1'b0;
                end else begin
                    n_re  = w_dre[DW-1:0];
                    n_im  = w_dim[DW-1:0];
                    n_sat = w_dre[DW] | w_dim[DW];
                end
            end
            cau_pkg::FUNC_MOD, cau_pkg::FUNC_DIST: begin
                n_re  = w_e.sq_sat ? POS_MAX : w_root[DW-1:0];
                n_im  = '0;
                n_sat = w_e.sq_sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_sv[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res_re    <= n_re;
        o_res_im    <= n_im;
        o_cmp_sign  <= n_cmp;
        o_div_zero  <= n_dz;
        o_saturated <= n_sat;
    end

endmodule

// File: src/cau_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor((num << FRAC_BITS) / den), 32 quotient bits.
// Flags overflow when the quotient needs more bits. Uses cau_pkg.
module cau_div_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic [cau_pkg::MW-1:0]   i_num,
    input  logic [cau_pkg::MW-1:0]   i_den,
    output logic [cau_pkg::DW-1:0]   o_quo,
    output logic                     o_ovf
);

    localparam int NW = cau_pkg::MW + FRAC_BITS;
    localparam int MW = cau_pkg::MW;
    localparam int DW = cau_pkg::DW;
    localparam int ST = cau_pkg::DIV_STEPS;

    logic [MW-1:0] r_num;
    logic [MW-1:0] r_den;
    logic [NW-1:0] w_n;
    logic [MW-1:0] w_hi;

    logic [MW-1:0] r_rem [ST+1];
    logic [DW-1:0] r_lo  [ST+1];
    logic [DW-1:0] r_q   [ST+1];
    logic [MW-1:0] r_dv  [ST+1];
    logic          r_ovf [ST+1];

    always_ff @(posedge i_clk) begin
        r_num <= i_num;
        r_den <= i_den;
    end

    assign w_n  = {r_num, {FRAC_BITS{1'b0}}};
    assign w_hi = MW'(w_n[NW-1:DW]);

    // quotient fits in DW bits only when the top part is below the divisor
    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_hi;
        r_lo[0]  <= w_n[DW-1:0];
        r_q[0]   <= '0;
        r_dv[0]  <= r_den;
        r_ovf[0] <= (w_hi >= r_den);
    end

    for (genvar k = 0; k < ST; k++) begin : g_step
        logic [MW:0] w_t;
        logic [MW:0] w_d;
        logic        w_ge;

        assign w_t  = {r_rem[k], r_lo[k][DW-1]};
        assign w_ge = (w_t >= {1'b0, r_dv[k]});
        assign w_d  = w_t - {1'b0, r_dv[k]};

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_ge ? w_d[MW-1:0] : w_t[MW-1:0];
            r_lo[k+1]  <= {r_lo[k][DW-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][DW-2:0], w_ge};
            r_dv[k+1]  <= r_dv[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_quo = r_q[ST];
    assign o_ovf = r_ovf[ST];

endmodule

// File: src/cau_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, floor, one root bit per stage.
// Uses cau_pkg for the step count.
module cau_sqrt_pipe (
    input  logic                               i_clk,
    input  logic [2*cau_pkg::SQRT_STEPS-1:0]   i_rad,
    output logic [cau_pkg::SQRT_STEPS-1:0]     o_root
);

    localparam int ST = cau_pkg::SQRT_STEPS;
    localparam int SW = 2 * ST;
    localparam int RW = ST + 2;

    logic [SW-1:0] r_s    [ST+1];
    logic [RW-1:0] r_rem  [ST+1];
    logic [ST-1:0] r_root [ST+1];

    always_ff @(posedge i_clk) begin
        r_s[0]    <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar k = 0; k < ST; k++) begin : g_step
        logic [RW+1:0] w_t;
        logic [RW+1:0] w_trial;
        logic [RW+1:0] w_d;
        logic          w_ge;

        assign w_t     = {r_rem[k], r_s[k][SW-1:SW-2]};
        assign w_trial = (RW+2)'({r_root[k], 2'b01});
        assign w_ge    = (w_t >= w_trial);
        assign w_d     = w_t - w_trial;

        always_ff @(posedge i_clk) begin
            r_s[k+1]    <= {r_s[k][SW-3:0], 2'b00};
            r_rem[k+1]  <= w_ge ? w_d[RW-1:0] : w_t[RW-1:0];
            r_root[k+1] <= {r_root[k][ST-2:0], w_ge};
        end
    end

    assign o_root = r_root[ST];

endmodule

// File: tb/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for complex_arithmetic_unit: checks every result against an exact
// predictor of the Q16.16 arithmetic. Depends on cau_pkg and the block's RTL.
module complex_arithmetic_unit_tb;

    localparam int FB = 16;
    localparam int LAT = 38;
    localparam longint LIMIT = 400000;

    typedef struct {
        logic [3:0]         func;
        logic signed [31:0] a_re, a_im, b_re, b_im;
    } t_op;

    typedef struct {
        logic signed [31:0] re, im;
        logic signed [1:0]  cmp;
        logic               dz, sat;
    } t_res;

    logic i_clk = 0, i_rst_n = 0, start = 0;
    logic [3:0] i_func = 0;
    logic signed [31:0] i_a_re = 0, i_a_im = 0, i_b_re = 0, i_b_im = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;
    wire busy, o_done, o_div_zero, o_saturated, pready;
    wire signed [31:0] o_res_re, o_res_im;
    wire signed [1:0] o_cmp_sign;
    wire [31:0] prdata;

    complex_arithmetic_unit #(.FRAC_BITS(FB)) dut (.*);

    t_op  pending_ops[$];
    t_res expected_results[$];
    logic [30:0] thr_shadow = 0;
    int   idle_pct = 0;
    int   errors = 0;
    longint cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // exact arithmetic on wide signed values
    function automatic logic signed [31:0] clamp(logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] floor_shift(logic signed [127:0] v,
                                                       inout logic sat);
        return clamp(v >>> FB, sat);
    endfunction

    function automatic logic signed [31:0] quot(logic signed [127:0] num,
                                                logic [127:0] den, inout logic sat);
        logic [127:0] m, q;
        logic signed [127:0] sq;
        m = num < 0 ? -num : num;
        q = (m << FB) / den;
        if (q > 128'h7fffffffffff) q = 128'hffffffffffff;
        sq = num < 0 ? -$signed(q) : $signed(q);
        return clamp(sq, sat);
    endfunction

    function automatic logic signed [31:0] root(logic [127:0] s, inout logic sat);
        logic [127:0] r, b;
        if (s >= (128'd1 << 62)) begin
            sat = 1;
            return 32'sh7fffffff;
        end
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (128'd1 << i);
            if (b * b <= s) r = b;
        end
        return r[31:0];
    endfunction

    function automatic t_res predict_result(t_op op);
        t_res r;
        logic signed [127:0] ar, ai, br, bi, nr, ni, dr, di;
        logic [127:0] den, ma, mb;
        logic s;
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        r = '{default: 0};
        s = 0;
        case (op.func)
            cau_pkg::FUNC_ADD: begin
                r.re = clamp(ar + br, s); r.im = clamp(ai + bi, s);
            end
            cau_pkg::FUNC_SUB: begin
                r.re = clamp(ar - br, s); r.im = clamp(ai - bi, s);
            end
            cau_pkg::FUNC_MUL: begin
                r.re = floor_shift(ar * br - ai * bi, s);
                r.im = floor_shift(ar * bi + ai * br, s);
            end
            cau_pkg::FUNC_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) r.dz = 1;
                else begin
                    nr = ar * br + ai * bi;
                    ni = ai * br - ar * bi;
                    r.re = quot(nr, den, s); r.im = quot(ni, den, s);
                end
            end
            cau_pkg::FUNC_CONJ: begin
                r.re = op.a_re; r.im = clamp(-ai, s);
            end
            cau_pkg::FUNC_SCALE: begin
                r.re = floor_shift(ar * br, s); r.im = floor_shift(ai * br, s);
            end
            cau_pkg::FUNC_DIVR: begin
                if (br == 0) r.dz = 1;
                else begin
                    den = br < 0 ? -br : br;
                    r.re = quot(br < 0 ? -ar : ar, den, s);
                    r.im = quot(br < 0 ? -ai : ai, den, s);
                end
            end
            cau_pkg::FUNC_SQMOD: r.re = floor_shift(ar * ar + ai * ai, s);
            cau_pkg::FUNC_MOD:   r.re = root(ar * ar + ai * ai, s);
            cau_pkg::FUNC_DIST: begin
                dr = ar - br; di = ai - bi;
                r.re = root(dr * dr + di * di, s);
            end
            cau_pkg::FUNC_CMP: begin
                ma = ar * ar + ai * ai; mb = br * br + bi * bi;
                r.cmp = ma > mb ? 2'sd1 : (ma < mb ? -2'sd1 : 2'sd0);
            end
            cau_pkg::FUNC_THR: begin
                r.re = ((ar < 0 ? -ar : ar) < thr_shadow) ? 0 : op.a_re;
                r.im = ((ai < 0 ? -ai : ai) < thr_shadow) ? 0 : op.a_im;
            end
            default: ;
        endcase
        r.sat = s;
        return r;
    endfunction

    // driver: one item per accepted start
    always @(negedge i_clk) begin
        if (i_rst_n && pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
            t_op op;
            op = pending_ops.pop_front();
            start <= 1;
            i_func <= op.func; i_a_re <= op.a_re; i_a_im <= op.a_im;
            i_b_re <= op.b_re; i_b_im <= op.b_im;
        end else begin
            start <= 0;
        end
    end

    // predict at acceptance so the threshold in force is used
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_results.push_back(predict_result('{i_func, i_a_re, i_a_im,
                                                        i_b_re, i_b_im}));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("result with no item waiting");
                errors++;
            end else begin
                t_res e;
                e = expected_results.pop_front();
                if (o_res_re !== e.re) begin
                    $error("res_re exp %h got %h", e.re, o_res_re); errors++;
                end
                if (o_res_im !== e.im) begin
                    $error("res_im exp %h got %h", e.im, o_res_im); errors++;
                end
                if (o_cmp_sign !== e.cmp) begin
                    $error("cmp_sign exp %0d got %0d", e.cmp, o_cmp_sign); errors++;
                end
                if (o_div_zero !== e.dz) begin
                    $error("div_zero exp %b got %b", e.dz, o_div_zero); errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated); errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(logic [3:0] f, logic [31:0] ar, ai, br, bi);
        pending_ops.push_back('{f, ar, ai, br, bi});
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [30:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {cau_pkg::REG_THRESHOLD, 2'b00};
        pwdata <= {1'b0, v} | ($urandom & 32'h80000000);
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        thr_shadow = v;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++)
            queue_item(4'($urandom_range(15)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        write_threshold(31'h0001_0000);
        // directed: extremes, every func, zero divisors, negation of the minimum
        for (int f = 0; f < 16; f++)
            queue_item(4'(f), 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        queue_item(cau_pkg::FUNC_DIV, 32'h00010000, 32'h00020000, 0, 0);
        queue_item(cau_pkg::FUNC_DIVR, 32'h00010000, 32'hfffe0000, 0, 32'h5);
        queue_item(cau_pkg::FUNC_CONJ, 32'h1, 32'h80000000, 0, 0);
        queue_item(cau_pkg::FUNC_CMP, 32'h00030000, 32'h00040000, 32'h00050000, 0);
        queue_item(cau_pkg::FUNC_CMP, 32'h1, 0, 32'h2, 0);
        queue_item(cau_pkg::FUNC_THR, 32'h0000ffff, 32'hffff0001, 0, 0);
        queue_item(cau_pkg::FUNC_THR, 32'h00010000, 32'hffff0000, 0, 0);
        queue_item(cau_pkg::FUNC_DIVR, 32'h7fffffff, 32'h80000000, 32'h1, 0);
        queue_item(cau_pkg::FUNC_MOD, 32'h7fffffff, 32'h7fffffff, 0, 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 74 : (ph == 3) ? 38 : 0;
            case (ph)
                0: write_threshold(31'h7fffffff);
                1: write_threshold(31'd0);
                default: write_threshold(31'($urandom));
            endcase
            queue_random(80);
            while (pending_ops.size() > 0) @(posedge i_clk);
            // hold off until every result is back
            while (expected_results.size() > 0) @(posedge i_clk);
            queue_random(80);
            drain();
        end

        if (errors == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
